// ===== rtl/sliding_window_mean_stddev_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Sliding window statistics: assertion macros
// Concurrent assertion shorthands clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEAN_STDDEV_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MEAN_STDDEV_UNIT_ASSERT_SVH

// Property checked only while the block is out of reset.
`define SWMSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define SWMSD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/swmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistics: package
// Default parameter values and the widths and positions of the stream fields.
// ----------------------------------------------------------------------------
`default_nettype none

package swmsd_pkg;

	localparam int MAX_WINDOW_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int LEN_W    = 11;
	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 11;
	localparam int MEAN_W   = 16;
	localparam int STD_W    = 16;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - COUNT_W - MEAN_W - STD_W;

	localparam int MEAN_LSB = COUNT_W;
	localparam int STD_LSB  = COUNT_W + MEAN_W;

endpackage

`default_nettype wire

// ===== rtl/swmsd_div.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistics: serial divider
// Restoring unsigned divider producing one quotient bit per cycle. The caller
// guarantees that the quotient fits in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module swmsd_div #(
	parameter int QW = 16,
	parameter int DW = 11
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [QW+DW-1:0]   dividend,
	input  wire logic [DW-1:0]      divisor,
	output logic                    busy,
	output logic [QW-1:0]           quotient
);

	localparam int CNTW = $clog2(QW + 1);

	logic [DW-1:0]   rem_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [DW+1:0]   trial;
	logic            borrow;

	assign trial  = {1'b0, rem_q, quo_q[QW-1]} - {2'b00, divisor};
	assign borrow = trial[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNTW'(1);
			if (cnt_q == CNTW'(QW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[QW+DW-1:QW];
			quo_q <= dividend[QW-1:0];
		end else if (busy_q) begin
			if (!borrow) begin
				rem_q <= trial[DW-1:0];
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[QW-1]};
			end
			quo_q <= {quo_q[QW-2:0], ~borrow};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_mean_stddev_unit.sv =====
// ----------------------------------------------------------------------------
// Sliding window mean and standard deviation unit
// Keeps the most recent window_len samples and, for every sample taken in,
// returns the fill count, the truncated mean and the integer sample standard
// deviation of the window.
// ----------------------------------------------------------------------------
// One sample is processed at a time: a new sample is taken only once the unit
// is back in its idle state after the previous one. The work is done by three
// bit-serial units run in turn: the shift-add multipliers forming n*sum_sq,
// sum^2 and n*(n-1), the restoring divider for the variance, and the
// digit-by-digit square root; the mean is divided while the multipliers run.
// While fewer than two samples are held the divider and the square root are
// skipped. A finished result waits in the output register, so the next sample
// is accepted while it is still held; a result that cannot leave because the
// one before it is still stalled on the result stream holds the unit until the
// stream takes the earlier one. Writing window_len clears the window; it is
// taken only while no sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_mean_stddev_unit
	import swmsd_pkg::*;
#(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [LEN_W-1:0]       cfg_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample_value
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // [10:0] sample_count,
	                                                    // [26:11] window_mean,
	                                                    // [42:27] window_std_dev
);

	localparam int SB   = SAMPLE_BITS;
	localparam int CW   = $clog2(MAX_WINDOW + 1);
	localparam int AW   = $clog2(MAX_WINDOW);
	localparam int SUMW = SB + CW;
	localparam int SQW  = 2 * SB - 1 + CW;
	localparam int PW   = 2 * SUMW;
	localparam int QW   = 2 * SB;
	localparam int DENW = 2 * CW;
	localparam int CNTW = $clog2(SUMW + 1);
	localparam int SDW  = (SB > STD_W) ? SB : STD_W;
	localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;
	localparam int INW  = (SB > SAMPLE_W) ? SB : SAMPLE_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_UPD   = 4'd1;
	localparam logic [3:0] ST_SQ    = 4'd2;
	localparam logic [3:0] ST_LOAD  = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_DIVST = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_SQRT  = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0]              state_q;
	logic [CW-1:0]           len_q;
	logic [AW-1:0]           slot_q;
	logic [CW-1:0]           fill_q;
	logic signed [SUMW-1:0]  sum_q;
	logic [SQW-1:0]          sumsq_q;
	logic                    m_valid_q;
	logic [OUT_TDATA_W-1:0]  m_data_q;

	logic signed [SB-1:0]    sample_ring_q [MAX_WINDOW];
	logic signed [SB-1:0]    old_q;
	logic signed [SB-1:0]    samp_q;
	logic signed [2*SB+1:0]  dsq_q;
	logic                    neg_q;
	logic [PW-1:0]           mca_q;
	logic [PW-1:0]           mcb_q;
	logic [DENW-1:0]         mcc_q;
	logic [CW-1:0]           mpa_q;
	logic [SUMW-1:0]         mpb_q;
	logic [CW-1:0]           mpc_q;
	logic [PW-1:0]           acc_a_q;
	logic [PW-1:0]           acc_b_q;
	logic [DENW-1:0]         acc_c_q;
	logic [CNTW-1:0]         cnt_q;
	logic [QW-1:0]           x_q;
	logic [SB-1:0]           rem_q;
	logic [SB-1:0]           root_q;

	logic                    s_acc;
	logic                    cfg_acc;
	logic [INW-1:0]          samp_raw;
	logic                    full;
	logic signed [SB-1:0]    old_sel;
	logic signed [SB:0]      dif;
	logic signed [SB:0]      adds;
	logic [CW-1:0]           slot_nx;
	logic [SUMW-1:0]         mag;
	logic [CMPW-1:0]         len_in;
	logic [CW-1:0]           len_new;
	logic                    out_free;
	logic                    mdiv_start;
	logic                    mdiv_busy;
	logic [SB-1:0]           mdiv_quo;
	logic                    vdiv_start;
	logic                    vdiv_busy;
	logic [QW-1:0]           vdiv_quo;
	logic [SB+1:0]           sq_cat;
	logic [SB+2:0]           sq_trial;
	logic signed [SB-1:0]    mean_s;
	logic [SDW-1:0]          root_ext;
	logic [STD_W-1:0]        std_out;
	logic [MEAN_W-1:0]       mean_out;
	logic [COUNT_W-1:0]      count_out;

	assign cfg_ready     = (state_q == ST_IDLE);
	assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	assign samp_raw = INW'(s_axis_tdata);
	assign full     = (fill_q >= len_q);
	assign old_sel  = full ? old_q : '0;
	assign dif      = (SB+1)'(samp_q) - (SB+1)'(old_sel);
	assign adds     = (SB+1)'(samp_q) + (SB+1)'(old_sel);
	assign slot_nx  = CW'(slot_q) + CW'(1);
	assign mag      = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);

	always_comb begin
		len_in = CMPW'(cfg_data);
		if (len_in == '0) begin
			len_new = CW'(1);
		end else if (len_in > CMPW'(MAX_WINDOW)) begin
			len_new = CW'(MAX_WINDOW);
		end else begin
			len_new = len_in[CW-1:0];
		end
	end

	assign mdiv_start = (state_q == ST_LOAD);
	assign vdiv_start = (state_q == ST_DIVST);

	swmsd_div #(
		.QW (SB),
		.DW (CW)
	) u_mean_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mdiv_start),
		.dividend (mag),
		.divisor  (fill_q),
		.busy     (mdiv_busy),
		.quotient (mdiv_quo)
	);

	swmsd_div #(
		.QW (QW),
		.DW (DENW)
	) u_var_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (vdiv_start),
		.dividend (acc_a_q - acc_b_q),
		.divisor  (acc_c_q),
		.busy     (vdiv_busy),
		.quotient (vdiv_quo)
	);

	assign sq_cat   = {rem_q, x_q[QW-1 -: 2]};
	assign sq_trial = {1'b0, sq_cat} - {1'b0, root_q, 2'b01};

	assign mean_s    = neg_q ? -$signed(mdiv_quo) : $signed(mdiv_quo);
	assign mean_out  = MEAN_W'(mean_s);
	assign root_ext  = SDW'(root_q);
	assign std_out   = (root_ext > SDW'({STD_W{1'b1}})) ? {STD_W{1'b1}} : root_ext[STD_W-1:0];
	assign count_out = COUNT_W'(fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= CW'(MAX_WINDOW);
			slot_q  <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						len_q   <= len_new;
						slot_q  <= '0;
						fill_q  <= '0;
						sum_q   <= '0;
						sumsq_q <= '0;
					end else if (s_acc) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					sum_q <= sum_q + SUMW'(samp_q) - SUMW'(old_sel);
					if (!full) begin
						fill_q <= fill_q + CW'(1);
					end
					if (slot_nx >= len_q) begin
						slot_q <= '0;
					end else begin
						slot_q <= slot_nx[AW-1:0];
					end
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					sumsq_q <= sumsq_q + SQW'(dsq_q);
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == CNTW'(SUMW - 1) && !mdiv_busy) begin
						state_q <= (fill_q >= CW'(2)) ? ST_DIVST : ST_DONE;
					end
				end
				ST_DIVST: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!vdiv_busy) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q == CNTW'(SB - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		old_q <= sample_ring_q[slot_q];
		if (state_q == ST_UPD) begin
			sample_ring_q[slot_q] <= samp_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				samp_q <= $signed(samp_raw[SB-1:0]);
			end
			ST_UPD: begin
				dsq_q <= dif * adds;
			end
			ST_LOAD: begin
				neg_q   <= sum_q[SUMW-1];
				mca_q   <= PW'(sumsq_q);
				mpa_q   <= fill_q;
				mcb_q   <= PW'(mag);
				mpb_q   <= mag;
				mcc_q   <= DENW'(fill_q);
				mpc_q   <= fill_q - CW'(1);
				acc_a_q <= '0;
				acc_b_q <= '0;
				acc_c_q <= '0;
				cnt_q   <= '0;
			end
			ST_MUL: begin
				if (mpa_q[0]) begin
					acc_a_q <= acc_a_q + mca_q;
				end
				if (mpb_q[0]) begin
					acc_b_q <= acc_b_q + mcb_q;
				end
				if (mpc_q[0]) begin
					acc_c_q <= acc_c_q + mcc_q;
				end
				mca_q <= mca_q << 1;
				mcb_q <= mcb_q << 1;
				mcc_q <= mcc_q << 1;
				mpa_q <= mpa_q >> 1;
				mpb_q <= mpb_q >> 1;
				mpc_q <= mpc_q >> 1;
				cnt_q <= cnt_q + CNTW'(1);
				root_q <= '0;
			end
			ST_DIV: begin
				x_q    <= vdiv_quo;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			ST_SQRT: begin
				if (!sq_trial[SB+2]) begin
					rem_q  <= sq_trial[SB-1:0];
					root_q <= {root_q[SB-2:0], 1'b1};
				end else begin
					rem_q  <= sq_cat[SB-1:0];
					root_q <= {root_q[SB-2:0], 1'b0};
				end
				x_q   <= x_q << 2;
				cnt_q <= cnt_q + CNTW'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					m_data_q <= {{OUT_PAD_W{1'b0}}, std_out, mean_out, count_out};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== rtl/swmsd_chk.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistics: port checker
// Watches the stream ports of the unit over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_mean_stddev_unit_assert.svh"

module swmsd_chk
	import swmsd_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	`SWMSD_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !m_axis_tvalid, "result valid during reset")

	`SWMSD_ASSERT(a_one_sample_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "sample taken while another is in work")

	`SWMSD_ASSERT(a_count_nonzero, m_axis_tvalid |-> m_axis_tdata[COUNT_W-1:0] != '0, "result with empty window")

	`SWMSD_ASSERT(a_std_zero_single, m_axis_tvalid && m_axis_tdata[COUNT_W-1:0] == COUNT_W'(1) |-> m_axis_tdata[STD_LSB +: STD_W] == '0, "deviation not zero for one sample")

	`SWMSD_ASSERT(a_result_held, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind sliding_window_mean_stddev_unit swmsd_chk u_swmsd_chk (.*);

`default_nettype wire
